>>> hdl/window_mean_spread_detector_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the window mean/spread detector
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WINDOW_MEAN_SPREAD_DETECTOR_DEFINES_SVH
`define WINDOW_MEAN_SPREAD_DETECTOR_DEFINES_SVH

// same-cycle implication
`define WMSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WMSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/wmsd_pkg.sv
// ----------------------------------------------------------------------------
// wmsd_pkg
// Widths, register indexes, reset values and types of the detector.
// ----------------------------------------------------------------------------
package wmsd_pkg;

  localparam int DIST_W                = 10;
  localparam int LIMIT_W               = 23;
  localparam int SQ_W                  = 2 * DIST_W;
  localparam int CFG_IDX_W             = 1;
  localparam int CFG_DATA_W            = LIMIT_W;
  localparam int WINDOW_LENGTH_DEFAULT = 5;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_LIMIT   = 1'd1;

  localparam logic [DIST_W-1:0]  NEAR_THRESHOLD_RESET = 10'd180;
  localparam logic [LIMIT_W-1:0] SPREAD_LIMIT_RESET   = 23'd225;

  // control broadcast to every cell of the window
  typedef struct packed {
    logic advance;  // take the previous cell's sample, or the new sample at the head
    logic clear;    // load zero instead
  } cell_ctrl_t;

endpackage

>>> hdl/wmsd_cell.sv
// ----------------------------------------------------------------------------
// wmsd_cell
// One window entry: holds a sample, hands it on, squares its deviation.
// ----------------------------------------------------------------------------
module wmsd_cell
  import wmsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [DIST_W-1:0] shift_in,
  input  logic [DIST_W-1:0] mean,
  output logic [DIST_W-1:0] value,
  output logic [SQ_W-1:0]   dev_sq
);

  logic [DIST_W-1:0] dev;

  // deviation of the entry this cell holds once the window has shifted
  always_comb begin
    if (shift_in >= mean) begin
      dev = shift_in - mean;
    end else begin
      dev = mean - shift_in;
    end
    dev_sq = SQ_W'(dev) * SQ_W'(dev);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (ctrl.advance) begin
      value <= ctrl.clear ? '0 : shift_in;
    end
  end

endmodule

>>> hdl/wmsd_sum_tree.sv
// ----------------------------------------------------------------------------
// wmsd_sum_tree
// Balanced adder tree over the squared deviations of all cells.
// ----------------------------------------------------------------------------
module wmsd_sum_tree
  import wmsd_pkg::*;
#(
  parameter int N     = WINDOW_LENGTH_DEFAULT,
  parameter int OUT_W = SQ_W + $clog2(N)
)(
  input  logic [SQ_W-1:0]  leaf [N],
  output logic [OUT_W-1:0] sum
);

  localparam int P = 2 ** $clog2(N);

  logic [OUT_W-1:0] node [2*P-1];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign node[P-1+i] = OUT_W'(leaf[i]);
    end else begin : g_pad
      assign node[P-1+i] = '0;
    end
  end

  for (genvar j = 0; j < P - 1; j++) begin : g_node
    assign node[j] = node[2*j+1] + node[2*j+2];
  end

  assign sum = node[0];

endmodule

>>> hdl/window_mean_spread_detector.sv
// ----------------------------------------------------------------------------
// window_mean_spread_detector
// Sliding-window mean and spread test on a stream of distance samples.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on distance_cm with sample_valid/sample_stall; one result
//   beat (detected, window_mean) leaves on result_valid/result_stall for
//   every sample beat. A sample beat is taken at a clock edge where
//   sample_valid is high and sample_stall is low.
//   The result of a sample is registered and valid the cycle after it
//   is taken. Throughput is one sample per cycle while no result is held
//   by result_stall; the window total, mean, the per-cell squared
//   deviations and the adder tree all settle in the cycle the sample is taken.
//   While a result is held by result_stall, sample_stall is high and the
//   window holds; when the held result leaves, a new sample can be taken in
//   the same cycle. Reset (rst, synchronous) zeroes the window and total,
//   restores near_threshold to 180 and spread_limit_squared to 225, and
//   drops any pending result. sample_stall is high during reset.
//   Registers are written through cfg_write/cfg_index/cfg_data; the user
//   must write them only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`include "window_mean_spread_detector_defines.svh"

module window_mean_spread_detector
  import wmsd_pkg::*;
#(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEFAULT
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  logic [DIST_W-1:0]     distance_cm,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic                  detected,
  output logic [DIST_W-1:0]     window_mean
);

  localparam int TOTAL_W  = $clog2(WINDOW_LENGTH * ((2 ** DIST_W) - 1) + 1);
  localparam int SPREAD_W = SQ_W + $clog2(WINDOW_LENGTH);
  localparam int CMP_W    = (SPREAD_W > LIMIT_W) ? SPREAD_W : LIMIT_W;

  // floor(total / WINDOW_LENGTH) as a multiply by a rounded-up reciprocal,
  // exact over the whole range of the total
  localparam int RECIP_SHIFT = TOTAL_W + $clog2(WINDOW_LENGTH);
  localparam int RECIP_W     = TOTAL_W + 1;
  localparam int PROD_W      = TOTAL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] MEAN_RECIP =
    RECIP_W'(((2 ** RECIP_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH);

  logic [DIST_W-1:0]   near_threshold;
  logic [LIMIT_W-1:0]  spread_limit_squared;
  logic [TOTAL_W-1:0]  window_total;
  logic [TOTAL_W-1:0]  window_total_next;
  logic [DIST_W-1:0]   mean;
  logic [SPREAD_W-1:0] spread;
  logic                hit;
  logic                accept;
  cell_ctrl_t          ctrl;

  logic [DIST_W-1:0] cell_value [WINDOW_LENGTH];
  logic [SQ_W-1:0]   cell_sq    [WINDOW_LENGTH];

  assign sample_stall = rst | (result_valid & result_stall);
  assign accept       = sample_valid & ~sample_stall;

  // drop the oldest sample, add the new one
  assign window_total_next = window_total - TOTAL_W'(cell_value[WINDOW_LENGTH-1])
                           + TOTAL_W'(distance_cm);
  assign mean = DIST_W'((PROD_W'(window_total_next) * PROD_W'(MEAN_RECIP)) >> RECIP_SHIFT);

  assign ctrl.advance = accept;
  assign ctrl.clear   = hit;

  for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
    logic [DIST_W-1:0] shift_in;
    if (i == 0) begin : g_head
      assign shift_in = distance_cm;
    end else begin : g_body
      assign shift_in = cell_value[i-1];
    end
    wmsd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .shift_in (shift_in),
      .mean     (mean),
      .value    (cell_value[i]),
      .dev_sq   (cell_sq[i])
    );
  end

  wmsd_sum_tree #(
    .N     (WINDOW_LENGTH),
    .OUT_W (SPREAD_W)
  ) u_sum_tree (
    .leaf (cell_sq),
    .sum  (spread)
  );

  assign hit = (CMP_W'(spread) < CMP_W'(spread_limit_squared))
            && (mean < near_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold       <= NEAR_THRESHOLD_RESET;
      spread_limit_squared <= SPREAD_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NEAR_THRESHOLD: near_threshold       <= cfg_data[DIST_W-1:0];
        REG_SPREAD_LIMIT:   spread_limit_squared <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_total <= '0;
    end else if (accept) begin
      window_total <= hit ? '0 : window_total_next;
    end
  end

  // output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      detected    <= hit;
      window_mean <= mean;
    end
  end

  `WMSD_ASSERT_NEXT(a_accept_gives_result, accept, result_valid,
                    "taken sample beat produced no result")
  `WMSD_ASSERT_NEXT(a_hit_clears_total, accept && hit, window_total == '0,
                    "detection did not clear the window total")
  `WMSD_ASSERT_NOW(a_detect_is_near, result_valid && detected,
                   window_mean < near_threshold,
                   "detection reported with mean not below threshold")

endmodule
